// ===== hw/rtl/utf8ws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 word splitter package
// Shared types, constants and character classification functions.
// ----------------------------------------------------------------------------
package utf8ws_pkg;

	localparam int unsigned MaxTextBytes = 65536;
	localparam logic [15:0] PosCap = (MaxTextBytes - 1 < 65535) ?
		16'(MaxTextBytes - 1) : 16'hFFFF;

	localparam int InTdataW  = 8;
	localparam int OutTdataW = 40;
	localparam int NumSlots  = 6;

	localparam logic [1:0] KindCjk   = 2'd0;
	localparam logic [1:0] KindAlpha = 2'd1;
	localparam logic [1:0] KindDigit = 2'd2;
	localparam logic [1:0] KindOther = 2'd3;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ALPHA = 2'd1,
		MODE_DIGIT = 2'd2
	} mode_t;

	typedef struct packed {
		logic [15:0] word_start;
		logic [15:0] word_end;
		logic [1:0]  word_kind;
		logic        last_in_run;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} slot_t;

	// Outcome of handing one decoded character to the word scanner.
	typedef struct packed {
		mode_t       mode;
		logic [15:0] ws;
		logic [15:0] we;
		slot_t       flush;
		slot_t       single;
	} take_t;

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] n);
		logic [16:0] sum;
		sum = {1'b0, a} + 17'(n);
		if (sum > {1'b0, PosCap}) begin
			return PosCap;
		end
		return sum[15:0];
	endfunction

	function automatic logic in_range(input logic [20:0] v, input logic [20:0] lo,
		input logic [20:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic logic cp_is_cjk(input logic [20:0] cp);
		return in_range(cp, 21'h4E00, 21'h9FFF) || in_range(cp, 21'h3400, 21'h4DBF) ||
			in_range(cp, 21'hF900, 21'hFAFF) || in_range(cp, 21'h3040, 21'h30FF);
	endfunction

	function automatic logic cp_is_letter(input logic [20:0] cp);
		return in_range(cp, 21'h61, 21'h7A) || in_range(cp, 21'h41, 21'h5A) ||
			in_range(cp, 21'h00C0, 21'h024F) || in_range(cp, 21'h0400, 21'h04FF) ||
			in_range(cp, 21'h0370, 21'h03FF) || in_range(cp, 21'h0600, 21'h06FF) ||
			in_range(cp, 21'h0900, 21'h097F) || in_range(cp, 21'h0E00, 21'h0E7F) ||
			in_range(cp, 21'h1E00, 21'h1EFF) || in_range(cp, 21'hAC00, 21'hD7AF) ||
			in_range(cp, 21'h1100, 21'h11FF);
	endfunction

	function automatic take_t take_char(input logic [20:0] cp, input logic [15:0] cs,
		input logic [2:0] len, input mode_t mode, input logic [15:0] ws,
		input logic [15:0] we);
		take_t       t;
		logic [15:0] cend;
		logic        is_ws;
		cend = sat_add(cs, len);
		is_ws = (len == 3'd1) && ((cp == 21'h20) || (cp == 21'h09) ||
			(cp == 21'h0A) || (cp == 21'h0D));
		t = '0;
		t.mode = mode;
		t.ws = ws;
		t.we = we;
		if (mode == MODE_ALPHA) begin
			if (cp_is_letter(cp) || (cp == 21'h2D) || (cp == 21'h5F)) begin
				t.we = cend;
				return t;
			end
			t.flush.valid = 1'b1;
			t.flush.res = '{word_start: ws, word_end: we, word_kind: KindAlpha,
				last_in_run: 1'b0};
			t.mode = MODE_IDLE;
		end
		if (is_ws) begin
			return t;
		end
		if (cp_is_cjk(cp)) begin
			t.single.valid = 1'b1;
			t.single.res = '{word_start: cs, word_end: cend, word_kind: KindCjk,
				last_in_run: 1'b0};
		end else if (cp_is_letter(cp)) begin
			t.mode = MODE_ALPHA;
			t.ws = cs;
			t.we = cend;
		end else if ((len == 3'd1) && in_range(cp, 21'h30, 21'h39)) begin
			t.mode = MODE_DIGIT;
			t.ws = cs;
			t.we = cend;
		end else begin
			t.single.valid = 1'b1;
			t.single.res = '{word_start: cs, word_end: cend, word_kind: KindOther,
				last_in_run: 1'b0};
		end
		return t;
	endfunction

endpackage

// ===== hw/rtl/utf8_word_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 word splitter
// Decodes a UTF-8 byte stream and reports word spans with their kind.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata (low bit up)                       | tlast
// s_axis   | in  | text_byte[7:0]                           | end_of_text
// m_axis   | out | word_start[15:0], word_end[31:16],       | last_in_run
//          |     | word_kind[33:32], zero fill [39:34]      |
//
// One text byte is taken per cycle while the queue has room. A byte is held
// in the input register, then its words go into a four-entry result queue
// read at one beat per cycle while m_axis_tready is high. The input register
// moves on only while the queue has room for two words.
// Reset clears the scan state and empties the queue; the text offset restarts
// at zero after each end of text.
// ----------------------------------------------------------------------------
module utf8_word_splitter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [utf8ws_pkg::InTdataW-1:0]   s_axis_tdata,  // text_byte
	input  logic                              s_axis_tlast,  // end_of_text
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [utf8ws_pkg::OutTdataW-1:0]  m_axis_tdata,  // start, end, kind
	output logic                              m_axis_tlast   // last_in_run
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       fire_s1;

	// Scan state.
	logic [15:0]       byte_position_q;
	utf8ws_pkg::mode_t scan_mode_q;
	logic [15:0]       word_start_q;
	logic [15:0]       word_end_q;
	logic [15:0]       char_start_q;
	logic [20:0]       cp_acc_q;
	logic [1:0]        bytes_left_q;
	logic [2:0]        char_len_q;

	// Result queue.
	utf8ws_pkg::res_t fifo_q [4];
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic [2:0]       count_q;
	logic             room;
	logic             pop;

	// Next-state values.
	logic [15:0]       pos_d;
	utf8ws_pkg::mode_t mode_d;
	logic [15:0]       ws_d;
	logic [15:0]       we_d;
	logic [15:0]       cs_d;
	logic [20:0]       acc_d;
	logic [1:0]        bl_d;
	logic [2:0]        clen_d;
	utf8ws_pkg::res_t  r0;
	utf8ws_pkg::res_t  r1;
	logic [1:0]        nres;

	assign room = (count_q <= 3'd2);
	assign fire_s1 = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eot_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		utf8ws_pkg::slot_t slots [utf8ws_pkg::NumSlots];
		utf8ws_pkg::take_t tc1;
		utf8ws_pkg::take_t tc2;
		logic              do_tc1;
		logic              fresh;
		logic [2:0]        len;
		logic [20:0]       lead_acc;
		logic [1:0]        n;

		for (int i = 0; i < utf8ws_pkg::NumSlots; i++) begin
			slots[i] = '0;
		end
		pos_d = byte_position_q;
		mode_d = scan_mode_q;
		ws_d = word_start_q;
		we_d = word_end_q;
		cs_d = char_start_q;
		acc_d = cp_acc_q;
		bl_d = bytes_left_q;
		clen_d = char_len_q;
		do_tc1 = 1'b0;
		fresh = 1'b0;

		case (byte_s1) inside
			8'b0???_????: begin
				len = 3'd1;
				lead_acc = 21'(byte_s1);
			end
			8'b110?_????: begin
				len = 3'd2;
				lead_acc = 21'(byte_s1[4:0]);
			end
			8'b1110_????: begin
				len = 3'd3;
				lead_acc = 21'(byte_s1[3:0]);
			end
			default: begin
				len = 3'd4;
				lead_acc = 21'(byte_s1[2:0]);
			end
		endcase

		if (bytes_left_q != 2'd0) begin
			acc_d = {cp_acc_q[14:0], byte_s1[5:0]};
			bl_d = bytes_left_q - 2'd1;
			do_tc1 = (bl_d == 2'd0);
		end else begin
			fresh = 1'b1;
			if (scan_mode_q == utf8ws_pkg::MODE_DIGIT) begin
				if ((byte_s1 >= 8'h30) && (byte_s1 <= 8'h39)) begin
					we_d = utf8ws_pkg::sat_add(byte_position_q, 3'd1);
					fresh = 1'b0;
				end else begin
					slots[0].valid = 1'b1;
					slots[0].res = '{word_start: word_start_q, word_end: word_end_q,
						word_kind: utf8ws_pkg::KindDigit, last_in_run: 1'b0};
					mode_d = utf8ws_pkg::MODE_IDLE;
				end
			end
			if (fresh) begin
				cs_d = byte_position_q;
				clen_d = len;
				acc_d = lead_acc;
				bl_d = 2'(len - 3'd1);
				do_tc1 = (len == 3'd1);
			end
		end

		tc1 = utf8ws_pkg::take_char(acc_d, cs_d, clen_d, mode_d, ws_d, we_d);
		if (do_tc1) begin
			mode_d = tc1.mode;
			ws_d = tc1.ws;
			we_d = tc1.we;
			slots[1] = tc1.flush;
			slots[2] = tc1.single;
		end

		// A character cut short by the end of text is classified from what came.
		tc2 = utf8ws_pkg::take_char(acc_d, cs_d, clen_d, mode_d, ws_d, we_d);
		if (eot_s1) begin
			if (bl_d != 2'd0) begin
				mode_d = tc2.mode;
				ws_d = tc2.ws;
				we_d = tc2.we;
				slots[3] = tc2.flush;
				slots[4] = tc2.single;
			end
			if (mode_d == utf8ws_pkg::MODE_ALPHA) begin
				slots[5].valid = 1'b1;
				slots[5].res = '{word_start: ws_d, word_end: we_d,
					word_kind: utf8ws_pkg::KindAlpha, last_in_run: 1'b0};
			end else if (mode_d == utf8ws_pkg::MODE_DIGIT) begin
				slots[5].valid = 1'b1;
				slots[5].res = '{word_start: ws_d, word_end: we_d,
					word_kind: utf8ws_pkg::KindDigit, last_in_run: 1'b0};
			end
			pos_d = '0;
			mode_d = utf8ws_pkg::MODE_IDLE;
			ws_d = '0;
			we_d = '0;
			cs_d = '0;
			acc_d = '0;
			bl_d = '0;
			clen_d = '0;
		end else begin
			pos_d = utf8ws_pkg::sat_add(byte_position_q, 3'd1);
		end

		// At most two words per byte; later ones are dropped.
		r0 = '0;
		r1 = '0;
		n = 2'd0;
		for (int i = 0; i < utf8ws_pkg::NumSlots; i++) begin
			if (slots[i].valid) begin
				if (n == 2'd0) begin
					r0 = slots[i].res;
					n = 2'd1;
				end else if (n == 2'd1) begin
					r1 = slots[i].res;
					n = 2'd2;
				end
			end
		end
		if (n == 2'd1) begin
			r0.last_in_run = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last_in_run = 1'b1;
		end
		nres = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			scan_mode_q <= utf8ws_pkg::MODE_IDLE;
			word_start_q <= '0;
			word_end_q <= '0;
			char_start_q <= '0;
			cp_acc_q <= '0;
			bytes_left_q <= '0;
			char_len_q <= '0;
		end else if (fire_s1) begin
			byte_position_q <= pos_d;
			scan_mode_q <= mode_d;
			word_start_q <= ws_d;
			word_end_q <= we_d;
			char_start_q <= cs_d;
			cp_acc_q <= acc_d;
			bytes_left_q <= bl_d;
			char_len_q <= clen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (fire_s1) begin
				wr_ptr_q <= wr_ptr_q + nres;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (fire_s1 ? 3'(nres) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (nres != 2'd0)) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (fire_s1 && (nres == 2'd2)) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	assign m_axis_tvalid = (count_q != 3'd0);
	assign m_axis_tdata = {6'd0, fifo_q[rd_ptr_q].word_kind, fifo_q[rd_ptr_q].word_end,
		fifo_q[rd_ptr_q].word_start};
	assign m_axis_tlast = fifo_q[rd_ptr_q].last_in_run;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 word splitter testbench
// Streams directed and random UTF-8 text into the splitter under three idling
// patterns, predicts every word span from its own scanner model and checks
// each output beat in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CycleLimit = 100000;
	localparam int SettleCycles = 20;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] past;
		logic [1:0]  kind;
		logic        last;
	} word_span_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [utf8ws_pkg::InTdataW-1:0]  s_axis_tdata = '0;  // text_byte
	logic                             s_axis_tlast = 1'b0; // end_of_text
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// word_start, word_end, word_kind, zero fill
	logic [utf8ws_pkg::OutTdataW-1:0] m_axis_tdata;
	logic                             m_axis_tlast;       // last_in_run

	utf8_word_splitter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_item_t text_bytes[$];
	word_span_t pending_spans[$];
	word_span_t step_spans[$];
	text_item_t next_item;
	word_span_t want;

	int tx_idle = 0;
	int rx_idle = 0;
	int queued_bytes = 0;
	int bytes_sent = 0;
	int texts_done = 0;
	int spans_seen = 0;
	int mismatch_count = 0;
	int cycles = 0;

	// Scanner state of the prediction.
	logic [15:0]       pos_r = '0;
	logic [15:0]       run_first = '0;
	logic [15:0]       run_past = '0;
	logic [15:0]       char_first = '0;
	utf8ws_pkg::mode_t mode_r = utf8ws_pkg::MODE_IDLE;
	logic [20:0]       cp_acc = '0;
	logic [1:0]        cont_due = '0;
	logic [2:0]        char_len = '0;

	function automatic void note_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endfunction

	function automatic logic [15:0] cap_add(logic [15:0] a, logic [2:0] n);
		logic [16:0] s;
		s = {1'b0, a} + 17'(n);
		return (s > {1'b0, utf8ws_pkg::PosCap}) ? utf8ws_pkg::PosCap : s[15:0];
	endfunction

	function automatic logic is_han_kana(logic [20:0] cp);
		return cp inside {[21'h4E00:21'h9FFF], [21'h3400:21'h4DBF], [21'hF900:21'hFAFF],
			[21'h3040:21'h30FF]};
	endfunction

	function automatic logic is_letter_cp(logic [20:0] cp);
		return cp inside {[21'h61:21'h7A], [21'h41:21'h5A], [21'h00C0:21'h024F],
			[21'h0370:21'h03FF], [21'h0400:21'h04FF], [21'h0600:21'h06FF],
			[21'h0900:21'h097F], [21'h0E00:21'h0E7F], [21'h1100:21'h11FF],
			[21'h1E00:21'h1EFF], [21'hAC00:21'hD7AF]};
	endfunction

	// Only the first two words of a byte are ever reported.
	function automatic void note_span(logic [15:0] first, logic [15:0] past, logic [1:0] kind);
		word_span_t sp;
		if (step_spans.size() < 2) begin
			sp.first = first;
			sp.past = past;
			sp.kind = kind;
			sp.last = 1'b0;
			step_spans.insert(step_spans.size(), sp);
		end
	endfunction

	function automatic void classify_char(logic [20:0] cp, logic [15:0] cs, logic [2:0] len);
		logic [15:0] cend;
		cend = cap_add(cs, len);
		if (mode_r == utf8ws_pkg::MODE_ALPHA) begin
			if (is_letter_cp(cp) || cp == 21'h2D || cp == 21'h5F) begin
				run_past = cend;
				return;
			end
			note_span(run_first, run_past, utf8ws_pkg::KindAlpha);
			mode_r = utf8ws_pkg::MODE_IDLE;
		end
		if (len == 3'd1 && cp inside {21'h20, 21'h09, 21'h0A, 21'h0D}) begin
			return;
		end
		if (is_han_kana(cp)) begin
			note_span(cs, cend, utf8ws_pkg::KindCjk);
		end else if (is_letter_cp(cp)) begin
			mode_r = utf8ws_pkg::MODE_ALPHA;
			run_first = cs;
			run_past = cend;
		end else if (len == 3'd1 && cp inside {[21'h30:21'h39]}) begin
			mode_r = utf8ws_pkg::MODE_DIGIT;
			run_first = cs;
			run_past = cend;
		end else begin
			note_span(cs, cend, utf8ws_pkg::KindOther);
		end
	endfunction

	// Advances the scanner by one accepted byte and queues the words it ends.
	function automatic void split_byte(logic [7:0] b, logic eot);
		logic [15:0] here;
		logic        fresh;
		logic [2:0]  len;
		logic [20:0] acc;
		here = pos_r;
		step_spans.delete();
		if (cont_due != 2'd0) begin
			cp_acc = {cp_acc[14:0], b[5:0]};
			cont_due = cont_due - 2'd1;
			if (cont_due == 2'd0) begin
				classify_char(cp_acc, char_first, char_len);
			end
		end else begin
			fresh = 1'b1;
			if (mode_r == utf8ws_pkg::MODE_DIGIT) begin
				if (b inside {[8'h30:8'h39]}) begin
					run_past = cap_add(here, 3'd1);
					fresh = 1'b0;
				end else begin
					note_span(run_first, run_past, utf8ws_pkg::KindDigit);
					mode_r = utf8ws_pkg::MODE_IDLE;
				end
			end
			if (fresh) begin
				case (b) inside
					8'b0???????: begin
						acc = {13'd0, b};
						len = 3'd1;
					end
					8'b110?????: begin
						acc = {16'd0, b[4:0]};
						len = 3'd2;
					end
					8'b1110????: begin
						acc = {17'd0, b[3:0]};
						len = 3'd3;
					end
					default: begin
						acc = {18'd0, b[2:0]};
						len = 3'd4;
					end
				endcase
				char_first = here;
				char_len = len;
				cp_acc = acc;
				cont_due = 2'(len - 3'd1);
				if (len == 3'd1) begin
					classify_char(acc, here, 3'd1);
				end
			end
		end
		if (eot) begin
			// A character cut short by the end of text is judged on the bits present.
			if (cont_due != 2'd0) begin
				cont_due = 2'd0;
				classify_char(cp_acc, char_first, char_len);
			end
			if (mode_r == utf8ws_pkg::MODE_ALPHA) begin
				note_span(run_first, run_past, utf8ws_pkg::KindAlpha);
			end else if (mode_r == utf8ws_pkg::MODE_DIGIT) begin
				note_span(run_first, run_past, utf8ws_pkg::KindDigit);
			end
			pos_r = '0;
			mode_r = utf8ws_pkg::MODE_IDLE;
			run_first = '0;
			run_past = '0;
			char_first = '0;
			cp_acc = '0;
			cont_due = '0;
			char_len = '0;
		end else begin
			pos_r = cap_add(here, 3'd1);
		end
		if (step_spans.size() != 0) begin
			step_spans[step_spans.size() - 1].last = 1'b1;
		end
		foreach (step_spans[i]) begin
			pending_spans.insert(pending_spans.size(), step_spans[i]);
		end
	endfunction

	// Sender side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				split_byte(s_axis_tdata, s_axis_tlast);
				bytes_sent++;
				if (s_axis_tlast) begin
					texts_done++;
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (text_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
					next_item = text_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_item.text_byte;
					s_axis_tlast <= next_item.end_of_text;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver side: every output beat is checked against the oldest predicted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				spans_seen++;
				if (pending_spans.size() == 0) begin
					note_error($sformatf("unexpected word start=%0d end=%0d kind=%0d last=%0b",
						m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[33:32],
						m_axis_tlast));
				end else begin
					want = pending_spans.pop_front();
					if (m_axis_tdata[15:0] !== want.first || m_axis_tdata[31:16] !== want.past ||
						m_axis_tdata[33:32] !== want.kind || m_axis_tlast !== want.last) begin
						note_error($sformatf(
							"word %0d expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
							spans_seen, want.first, want.past, want.kind, want.last,
							m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[33:32],
							m_axis_tlast));
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Run stopped after %0d cycles with %0d words outstanding.", cycles,
				pending_spans.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void queue_text_byte(logic [7:0] b);
		text_item_t it;
		it.text_byte = b;
		it.end_of_text = 1'b0;
		text_bytes.insert(text_bytes.size(), it);
		queued_bytes++;
	endfunction

	function automatic void mark_end_of_text();
		if (text_bytes.size() != 0) begin
			text_bytes[text_bytes.size() - 1].end_of_text = 1'b1;
		end
	endfunction

	// Encodes a code point in len bytes (overlong forms allowed) and queues the first keep.
	function automatic void queue_char(logic [20:0] cp, int len, int keep);
		logic [7:0] enc[4];
		enc[1] = {2'b10, cp[17:12]};
		enc[2] = {2'b10, cp[11:6]};
		enc[3] = {2'b10, cp[5:0]};
		case (len)
			1: enc[0] = {1'b0, cp[6:0]};
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: enc[0] = {5'b11110, cp[20:18]};
		endcase
		for (int i = 0; i < keep; i++) begin
			queue_text_byte(enc[i]);
		end
	endfunction

	function automatic logic [20:0] pick_two_byte_cp();
		case ($urandom_range(0, 4))
			0: return 21'($urandom_range(16'h024F, 16'h00C0));
			1: return 21'($urandom_range(16'h03FF, 16'h0370));
			2: return 21'($urandom_range(16'h04FF, 16'h0400));
			3: return 21'($urandom_range(16'h06FF, 16'h0600));
			default: return 21'($urandom_range(16'h07FF, 16'h0080));
		endcase
	endfunction

	function automatic logic [20:0] pick_three_byte_cp();
		case ($urandom_range(0, 9))
			0: return 21'($urandom_range(16'h9FFF, 16'h4E00));
			1: return 21'($urandom_range(16'h4DBF, 16'h3400));
			2: return 21'($urandom_range(16'hFAFF, 16'hF900));
			3: return 21'($urandom_range(16'h30FF, 16'h3040));
			4: return 21'($urandom_range(16'hD7AF, 16'hAC00));
			5: return 21'($urandom_range(16'h097F, 16'h0900));
			6: return 21'($urandom_range(16'h0E7F, 16'h0E00));
			7: return 21'($urandom_range(16'h1EFF, 16'h1E00));
			8: return 21'($urandom_range(16'h11FF, 16'h1100));
			default: return 21'($urandom_range(16'hFFFF, 16'h0800));
		endcase
	endfunction

	// Mostly well-formed characters and runs, with some truncated and stray bytes.
	function automatic void queue_token();
		int          r;
		int          n;
		int          len;
		logic [20:0] cp;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0: queue_text_byte(8'h2D);
					1: queue_text_byte(8'h5F);
					2, 3, 4: queue_text_byte(8'($urandom_range(8'h5A, 8'h41)));
					default: queue_text_byte(8'($urandom_range(8'h7A, 8'h61)));
				endcase
			end
		end else if (r < 30) begin
			n = $urandom_range(1, 5);
			repeat (n) queue_text_byte(8'($urandom_range(8'h39, 8'h30)));
		end else if (r < 44) begin
			case ($urandom_range(0, 3))
				0: queue_text_byte(8'h20);
				1: queue_text_byte(8'h09);
				2: queue_text_byte(8'h0A);
				default: queue_text_byte(8'h0D);
			endcase
		end else if (r < 52) begin
			queue_text_byte(8'($urandom_range(8'h7F, 8'h00)));
		end else if (r < 62) begin
			queue_char(pick_two_byte_cp(), 2, 2);
		end else if (r < 72) begin
			queue_char(pick_three_byte_cp(), 3, 3);
		end else if (r < 77) begin
			queue_char(21'($urandom_range(21'h1FFFFF, 21'h10000)), 4, 4);
		end else if (r < 82) begin
			// Overlong forms of a space, digits and other ASCII characters.
			len = $urandom_range(2, 4);
			case ($urandom_range(0, 2))
				0: cp = 21'h20;
				1: cp = 21'($urandom_range(8'h39, 8'h30));
				default: cp = 21'($urandom_range(8'h7F, 8'h00));
			endcase
			queue_char(cp, len, len);
		end else if (r < 89) begin
			len = $urandom_range(2, 4);
			cp = (len == 2) ? pick_two_byte_cp() :
				(len == 3) ? pick_three_byte_cp() : 21'($urandom_range(21'h1FFFFF, 0));
			queue_char(cp, len, $urandom_range(1, len - 1));
			if ($urandom_range(0, 1) == 0) begin
				mark_end_of_text();
			end
		end else begin
			queue_text_byte(8'($urandom_range(8'hFF, 8'h00)));
		end
		if ($urandom_range(0, 99) < 4) begin
			mark_end_of_text();
		end
	endfunction

	function automatic void queue_random_text(int count);
		int goal;
		goal = queued_bytes + count;
		while (queued_bytes < goal) begin
			queue_token();
		end
	endfunction

	task automatic wait_drained();
		while (text_bytes.size() != 0 || s_axis_tvalid || pending_spans.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle = 37;
		rx_idle = 70;
		// Alphabetic run with hyphen and underscore, broken by a digit run.
		queue_text_byte(8'h41);
		queue_text_byte(8'h2D);
		queue_text_byte(8'h7A);
		queue_text_byte(8'h5F);
		queue_text_byte(8'h30);
		queue_text_byte(8'h39);
		queue_text_byte(8'h09);
		queue_char(21'h00E9, 2, 2);
		queue_text_byte(8'h00);
		queue_char(21'h20, 2, 2);
		queue_char(21'h35, 2, 2);
		queue_char(21'h4E2D, 3, 3);
		queue_char(21'h1F600, 4, 4);
		// A byte of no known lead pattern swallows the next three bytes.
		queue_text_byte(8'hFF);
		queue_text_byte(8'h61);
		queue_text_byte(8'h62);
		queue_text_byte(8'h63);
		queue_text_byte(8'h0D);
		queue_char(21'h4E2D, 3, 2);
		mark_end_of_text();
		queue_random_text(600);
		wait_drained();

		tx_idle = 70;
		rx_idle = 37;
		queue_random_text(600);
		wait_drained();

		tx_idle = 0;
		rx_idle = 0;
		queue_random_text(600);
		queue_text_byte(8'h61);
		mark_end_of_text();
		wait_drained();

		repeat (SettleCycles) @(negedge clk);
		if (pending_spans.size() != 0) begin
			note_error($sformatf("%0d predicted words never arrived", pending_spans.size()));
		end
		$display("Sent %0d text bytes in %0d texts and checked %0d word beats.", bytes_sent,
			texts_done, spans_seen);
		$display("Mismatches: %0d.", mismatch_count);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/utf8ws_pkg.sv
hw/rtl/utf8_word_splitter_top.sv
bench/tb_top.sv
